@@ hw/rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, constants and helpers of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // occupancy word geometry
  localparam int WORD_BITS      = 32;
  localparam int POS_W          = 5;   // bit position inside a word
  localparam int ADDR_WORDS     = 32;  // words reachable by a 10-bit bit number
  localparam int WADDR_W        = 5;   // word number inside the reachable range
  localparam int CNT_W          = 6;   // word count, 0 to 32
  localparam int OP_W           = 3;
  localparam int BIT_W          = 10;
  localparam int WORD_COUNT_DEF = 32;

  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET   = 3'd0,
    OP_CLR   = 3'd1,
    OP_FIND  = 3'd2,
    OP_ALLOC = 3'd3,
    OP_CLRALL = 3'd4
  } op_t;

  // memory request from the controller
  typedef struct packed {
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr_en;
    logic [CNT_W-1:0]     clr_cnt;
  } mem_req_t;

  // position of the lowest zero bit, 0 when the word is full
  function automatic logic [POS_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) pos = POS_W'(b);
    end
    return pos;
  endfunction

endpackage

@@ hw/rtl/bfa_if.sv @@
// ----------------------------------------------------------------------------
// bfa channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------

// request channel
interface bfa_in_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [BIT_W-1:0] bit_index;
  modport source (output valid, output operation, output bit_index, input ready);
  modport sink   (input valid, input operation, input bit_index, output ready);
endinterface

// result channel
interface bfa_out_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [BIT_W-1:0] free_bit;
  logic             out_of_range;
  modport source (output valid, output found, output free_bit, output out_of_range,
                  input ready);
  modport sink   (input valid, input found, input free_bit, input out_of_range,
                  output ready);
endinterface

// configuration write channel
interface bfa_cfg_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/bfa_mem.sv @@
// ----------------------------------------------------------------------------
// bfa_mem
// Occupancy word store: one read and one write port, registered read data,
// per-word valid bits so that unwritten or cleared words read as zero.
// ----------------------------------------------------------------------------
module bfa_mem import bfa_pkg::*; #(
  parameter int DEPTH = ADDR_WORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mem_req_t             req,
  output logic [WORD_BITS-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  logic [WORD_BITS-1:0] rd_raw_r;
  logic                 rd_vld_r;

  // storage array: read and write
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr[AW-1:0]];
    end
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // valid bits: set on write, dropped by clear-all below the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr[AW-1:0]];
      end
      if (req.wr_en) begin
        vld_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.clr_en) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CNT_W'(i) < req.clr_cnt) vld_r[i] <= 1'b0;
        end
      end
    end
  end

  // a word never written since reset or clear reads as free
  assign rdata = rd_vld_r ? rd_raw_r : '0;

endmodule

@@ hw/rtl/bfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: read-modify-write for set and clear, word-by-word scan
// for find and allocate, result holding register toward the output.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [BIT_W-1:0]     in_bit_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [BIT_W-1:0]     out_free_bit,
  output logic                 out_out_of_range,
  input  logic [CNT_W-1:0]     active,
  output mem_req_t             req,
  input  logic [WORD_BITS-1:0] rdata
);

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_SCAN, S_DONE} state_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [WADDR_W-1:0] word_r, word_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               res_found_r, res_found_nxt;
  logic [BIT_W-1:0]   res_bit_r, res_bit_nxt;
  logic               res_oor_r, res_oor_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [BIT_W-1:0]   out_bit_r, out_bit_nxt;
  logic               out_oor_r, out_oor_nxt;

  logic [WADDR_W-1:0] in_word;
  logic [POS_W-1:0]   in_pos;
  logic [POS_W-1:0]   zero_pos;
  logic [CNT_W-1:0]   next_cnt;

  assign in_word  = in_bit_index[BIT_W-1:POS_W];
  assign in_pos   = in_bit_index[POS_W-1:0];
  assign zero_pos = lowest_zero(rdata);
  assign next_cnt = {1'b0, word_r} + CNT_W'(1);

  // sequencing and memory requests
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    word_nxt      = word_r;
    pos_nxt       = pos_r;
    res_found_nxt = res_found_r;
    res_bit_nxt   = res_bit_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_bit_nxt   = out_bit_r;
    out_oor_nxt   = out_oor_r;
    req           = '0;
    in_ready      = 1'b0;

    // output register drains independently of the sequencer
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_found_nxt = 1'b0;
          res_bit_nxt   = '0;
          res_oor_nxt   = 1'b0;
          op_nxt        = op_t'(in_operation);
          word_nxt      = in_word;
          pos_nxt       = in_pos;
          state_nxt     = S_DONE;
          case (in_operation)
            OP_SET, OP_CLR: begin
              if ({1'b0, in_word} < active) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_word;
                state_nxt   = S_RMW;
              end else begin
                res_oor_nxt = 1'b1;
              end
            end
            OP_FIND, OP_ALLOC: begin
              if (active != '0) begin
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
                word_nxt    = '0;
                state_nxt   = S_SCAN;
              end
            end
            OP_CLRALL: begin
              req.clr_en  = 1'b1;
              req.clr_cnt = active;
            end
            default: ;
          endcase
        end
      end

      // modify the word read at accept and write it back
      S_RMW: begin
        req.wr_en   = 1'b1;
        req.wr_addr = word_r;
        if (op_r == OP_SET) req.wr_data = rdata | (WORD_BITS'(1) << pos_r);
        else                req.wr_data = rdata & ~(WORD_BITS'(1) << pos_r);
        state_nxt = S_DONE;
      end

      // one word per cycle, stop at the first word with a free bit or after the last word in use
      S_SCAN: begin
        if (rdata != FULL_WORD) begin
          res_found_nxt = 1'b1;
          res_bit_nxt   = {word_r, zero_pos};
          if (op_r == OP_ALLOC) begin
            req.wr_en   = 1'b1;
            req.wr_addr = word_r;
            req.wr_data = rdata | (WORD_BITS'(1) << zero_pos);
          end
          state_nxt = S_DONE;
        end else if (next_cnt == active) begin
          state_nxt = S_DONE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = next_cnt[WADDR_W-1:0];
          word_nxt    = next_cnt[WADDR_W-1:0];
        end
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_bit_nxt   = res_bit_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    word_r      <= word_nxt;
    pos_r       <= pos_nxt;
    res_found_r <= res_found_nxt;
    res_bit_r   <= res_bit_nxt;
    res_oor_r   <= res_oor_nxt;
    out_found_r <= out_found_nxt;
    out_bit_r   <= out_bit_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_free_bit     = out_bit_r;
  assign out_out_of_range = out_oor_r;

endmodule

@@ hw/rtl/bitmap_first_free_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit bitmap allocator over a store of 32-bit occupancy words.
//
//   channel  direction  payload
//   in_ch    sink       operation[2:0], bit_index[9:0]
//   out_ch   source     found, free_bit[9:0], out_of_range
//   cfg_ch   sink       data[5:0] = words_in_use
//
// Set and clear go from accept through a read, a write back and the output
// load. Find and allocate scan the words in order, at most 32 of them: the
// single memory read port gives one word a cycle. Clear-all, out-of-range
// and undefined requests go straight to the output load.
// Reset is synchronous; all words read as free right after it, no sweep.
// A new request is taken while a result waits in the output register; a
// stalled output holds the following result in the sequencer.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator import bfa_pkg::*; #(
  parameter int WORD_COUNT = WORD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bfa_in_if.sink      in_ch,
  bfa_out_if.source   out_ch,
  bfa_cfg_if.sink     cfg_ch
);

  localparam int MEM_DEPTH = (WORD_COUNT < ADDR_WORDS) ? WORD_COUNT : ADDR_WORDS;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(MEM_DEPTH);

  logic [CNT_W-1:0]     words_r;
  logic [CNT_W-1:0]     active;
  mem_req_t             req;
  logic [WORD_BITS-1:0] rdata;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= CNT_W'(ADDR_WORDS);
    end else if (cfg_ch.valid) begin
      words_r <= cfg_ch.data;
    end
  end

  // effective word count, capped at the store depth
  assign active = (words_r > DEPTH_CNT) ? DEPTH_CNT : words_r;

  bfa_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_operation     (in_ch.operation),
    .in_bit_index     (in_ch.bit_index),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_found        (out_ch.found),
    .out_free_bit     (out_ch.free_bit),
    .out_out_of_range (out_ch.out_of_range),
    .active           (active),
    .req              (req),
    .rdata            (rdata)
  );

  bfa_mem #(
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata)
  );

endmodule

@@ hw/rtl/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             found,
  input logic [BIT_W-1:0] free_bit,
  input logic             out_of_range
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before being taken");

  // no result without a pending request
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != 2'd0))
    else $error("result delivered without a request");

  // at most one request in work and one result waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  // not found reports bit zero, and a range error never finds
  a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((found || (free_bit == '0)) && !(found && out_of_range)))
    else $error("inconsistent result fields");

endmodule

bind bitmap_first_free_allocator bfa_checker u_bfa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .found        (out_ch.found),
  .free_bit     (out_ch.free_bit),
  .out_of_range (out_ch.out_of_range)
);
